>>> hw/rtl/rc_packet_arm_and_stick_decoder_macros.svh
// Assertion helpers for the decoder RTL.
`ifndef RC_PACKET_ARM_AND_STICK_DECODER_MACROS_SVH
`define RC_PACKET_ARM_AND_STICK_DECODER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RCPAD_ASSERT_SAME(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// antecedent implies consequent in the next cycle
`define RCPAD_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

>>> hw/rtl/rcpad_pkg.sv
package rcpad_pkg;

	localparam int KEY_MAX          = 24;
	localparam int TRACKED_KEYS_DEF = 12;
	localparam int CLICK_W          = 12;
	localparam int CNT_W            = 16;
	localparam int QDEPTH           = 2;

	localparam logic [7:0]  HDR_OK        = 8'hAA;
	localparam logic [7:0]  STICK_CENTER  = 8'd127;
	localparam logic [10:0] THR_BASE      = 11'd1000;
	localparam logic [7:0]  ARM_THR_LIMIT = 8'd5;
	localparam logic [4:0]  TILT_SPAN     = 5'd30;
	localparam logic [4:0]  YAW_SPAN      = 5'd10;

	// x/127 == (x*8257) >> 20 for 0 <= x < 4096
	localparam logic [13:0] RECIP_127   = 14'd8257;
	localparam int          RECIP_SHIFT = 20;

	localparam logic [23:0] STOP_MASK_RST  = 24'd1;
	localparam logic [23:0] START_MASK_RST = 24'd2;

	typedef enum logic {
		REG_STOP_MASK  = 1'b0,
		REG_START_MASK = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic               hdr_ok;
		logic               stop_hit;
		logic               start_hit;
		logic               thr_low;
		logic [KEY_MAX-1:0] keys;
		logic [10:0]        throttle;
		logic signed [5:0]  pitch;
		logic signed [5:0]  roll;
		logic signed [4:0]  yaw;
	} item_t;

	// trunc((b-127)*span/127)
	function automatic logic signed [5:0] stick_scale(input logic [7:0] b,
			input logic [4:0] span);
		logic        neg;
		logic [7:0]  mag;
		logic [12:0] prod;
		logic [26:0] mul;
		logic [4:0]  q;
		neg  = (b < STICK_CENTER);
		mag  = neg ? (STICK_CENTER - b) : (b - STICK_CENTER);
		prod = 13'(mag) * 13'(span);
		mul  = 27'(prod) * 27'(RECIP_127);
		q    = 5'(mul >> RECIP_SHIFT);
		return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

endpackage

>>> hw/rtl/rcpad_front.sv
module rcpad_front import rcpad_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	input  logic [7:0]  header_byte,
	input  logic [23:0] key_word,
	input  logic [7:0]  throttle_byte,
	input  logic [7:0]  pitch_byte,
	input  logic [7:0]  roll_byte,
	input  logic [7:0]  yaw_byte,
	output item_t       item
);

	logic [23:0] stop_mask_q;
	logic [23:0] start_mask_q;
	reg_idx_t    idx;
	logic        wr_en;

	assign idx   = reg_idx_t'(paddr[2]);
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_mask_q  <= STOP_MASK_RST;
			start_mask_q <= START_MASK_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_STOP_MASK:  stop_mask_q  <= pwdata[23:0];
				REG_START_MASK: start_mask_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_STOP_MASK:  prdata = {8'd0, stop_mask_q};
			REG_START_MASK: prdata = {8'd0, start_mask_q};
			default:        prdata = '0;
		endcase
	end

	always_comb begin
		item.hdr_ok    = (header_byte == HDR_OK);
		item.stop_hit  = |(key_word & stop_mask_q);
		item.start_hit = |(key_word & start_mask_q);
		item.thr_low   = (throttle_byte < ARM_THR_LIMIT);
		item.keys      = key_word;
		item.throttle  = THR_BASE + {3'b0, throttle_byte} + {2'b0, throttle_byte, 1'b0};
		item.pitch     = stick_scale(pitch_byte, TILT_SPAN);
		item.roll      = stick_scale(roll_byte, TILT_SPAN);
		item.yaw       = 5'(stick_scale(yaw_byte, YAW_SPAN));
	end

endmodule

>>> hw/rtl/rcpad_fifo.sv
module rcpad_fifo import rcpad_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  valid,
	output item_t pop_item
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_QW = $clog2(QDEPTH + 1);

	item_t             mem_q [QDEPTH];
	logic [PTR_W-1:0]  wptr_q;
	logic [PTR_W-1:0]  rptr_q;
	logic [CNT_QW-1:0] count_q;

	assign full     = (count_q == CNT_QW'(QDEPTH));
	assign valid    = (count_q != '0);
	assign pop_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> hw/rtl/rcpad_back.sv
`include "rc_packet_arm_and_stick_decoder_macros.svh"

module rcpad_back import rcpad_pkg::*; #(
	parameter int TRACKED_KEYS = TRACKED_KEYS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  item_t             q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              accepted,
	output logic              armed,
	output logic [10:0]       throttle_command,
	output logic signed [5:0] pitch_target,
	output logic signed [5:0] roll_target,
	output logic signed [4:0] yaw_target,
	output logic [11:0]       click_flags
);

	logic                    armed_q;
	logic [10:0]             thr_q;
	logic signed [5:0]       pitch_q;
	logic signed [5:0]       roll_q;
	logic signed [4:0]       yaw_q;
	logic [CNT_W-1:0]        cnt_q [TRACKED_KEYS];
	logic [TRACKED_KEYS-1:0] click_q;

	logic                    armed_mid;
	logic                    armed_n;
	logic [10:0]             thr_n;
	logic signed [5:0]       pitch_n;
	logic signed [5:0]       roll_n;
	logic signed [4:0]       yaw_n;
	logic [CNT_W-1:0]        cnt_n [TRACKED_KEYS];
	logic [TRACKED_KEYS-1:0] click_n;
	logic [KEY_MAX-1:0]      click_pad;
	logic                    apply;

	logic                    out_valid_q;
	logic                    acc_q;
	logic                    arm_out_q;
	logic [10:0]             thr_out_q;
	logic signed [5:0]       pitch_out_q;
	logic signed [5:0]       roll_out_q;
	logic signed [4:0]       yaw_out_q;
	logic [11:0]             click_out_q;

	assign q_pop = q_valid && (!out_valid_q || !out_stall);
	assign apply = q_pop && q_item.hdr_ok;

	always_comb begin
		armed_mid = armed_q && !q_item.stop_hit;
		for (int i = 0; i < TRACKED_KEYS; i++) begin
			if (q_item.keys[i]) begin
				click_n[i] = (cnt_q[i] == '0);
				cnt_n[i]   = (cnt_q[i] == '1) ? cnt_q[i] : cnt_q[i] + 1'b1;
			end else begin
				click_n[i] = 1'b0;
				cnt_n[i]   = '0;
			end
		end
		if (armed_mid) begin
			thr_n   = q_item.throttle;
			pitch_n = q_item.pitch;
			roll_n  = q_item.roll;
			yaw_n   = q_item.yaw;
		end else begin
			thr_n   = THR_BASE;
			pitch_n = '0;
			roll_n  = '0;
			yaw_n   = '0;
		end
		armed_n = armed_mid || (q_item.start_hit && q_item.thr_low);
		click_pad = '0;
		click_pad[TRACKED_KEYS-1:0] = apply ? click_n : click_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			thr_q   <= THR_BASE;
			pitch_q <= '0;
			roll_q  <= '0;
			yaw_q   <= '0;
			click_q <= '0;
			for (int i = 0; i < TRACKED_KEYS; i++)
				cnt_q[i] <= '0;
		end else if (apply) begin
			armed_q <= armed_n;
			thr_q   <= thr_n;
			pitch_q <= pitch_n;
			roll_q  <= roll_n;
			yaw_q   <= yaw_n;
			click_q <= click_n;
			for (int i = 0; i < TRACKED_KEYS; i++)
				cnt_q[i] <= cnt_n[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (q_pop)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			acc_q       <= q_item.hdr_ok;
			arm_out_q   <= q_item.hdr_ok ? armed_n : armed_q;
			thr_out_q   <= q_item.hdr_ok ? thr_n : thr_q;
			pitch_out_q <= q_item.hdr_ok ? pitch_n : pitch_q;
			roll_out_q  <= q_item.hdr_ok ? roll_n : roll_q;
			yaw_out_q   <= q_item.hdr_ok ? yaw_n : yaw_q;
			click_out_q <= click_pad[CLICK_W-1:0];
		end
	end

	assign out_valid        = out_valid_q;
	assign accepted         = acc_q;
	assign armed            = arm_out_q;
	assign throttle_command = thr_out_q;
	assign pitch_target     = pitch_out_q;
	assign roll_target      = roll_out_q;
	assign yaw_target       = yaw_out_q;
	assign click_flags      = click_out_q;

	// live commands only leave an armed block
	`RCPAD_ASSERT_SAME(a_cmd_needs_arm, clk, arst_n, out_valid_q && (thr_out_q != THR_BASE), arm_out_q, "throttle command active while disarmed")
	// a rejected request reports the armed state unchanged
	`RCPAD_ASSERT_SAME(a_reject_holds, clk, arst_n, out_valid_q && !acc_q, arm_out_q == armed_q, "rejected request changed armed state")
	// arming needs an applied request with start keys and low throttle
	`RCPAD_ASSERT_NEXT(a_arm_cause, clk, arst_n, !armed_q && !(apply && q_item.start_hit && q_item.thr_low), !armed_q, "armed without start condition")

endmodule

>>> hw/rtl/rc_packet_arm_and_stick_decoder.sv
// Radio-control packet decoder: one request per packet, one result per request, one request
// per cycle sustained while out_stall is low. A request enters the front stage (header check,
// key masks, stick scaling), waits in a two-entry queue, and is applied to the arm state and
// per-key press counters in the back stage, whose result register feeds out_valid. out_valid
// rises when the back stage pops the request into that result register, a pop that out_stall
// can hold off. in_stall rises only when the queue is full, which happens when out_stall holds
// a waiting result. Requests with a header other than 0xAA return the held commands with
// accepted low. Write the masks over the APB port only while no request is in flight.
module rc_packet_arm_and_stick_decoder import rcpad_pkg::*; #(
	parameter int TRACKED_KEYS = TRACKED_KEYS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        header_byte,
	input  logic [23:0]       key_word,
	input  logic [7:0]        throttle_byte,
	input  logic [7:0]        pitch_byte,
	input  logic [7:0]        roll_byte,
	input  logic [7:0]        yaw_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              accepted,
	output logic              armed,
	output logic [10:0]       throttle_command,
	output logic signed [5:0] pitch_target,
	output logic signed [5:0] roll_target,
	output logic signed [4:0] yaw_target,
	output logic [11:0]       click_flags
);

	item_t front_item;
	item_t q_item;
	logic  q_full;
	logic  q_valid;
	logic  q_pop;
	logic  push;

	assign pready   = 1'b1;
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	rcpad_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.header_byte   (header_byte),
		.key_word      (key_word),
		.throttle_byte (throttle_byte),
		.pitch_byte    (pitch_byte),
		.roll_byte     (roll_byte),
		.yaw_byte      (yaw_byte),
		.item          (front_item)
	);

	rcpad_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_item  (q_item)
	);

	rcpad_back #(
		.TRACKED_KEYS (TRACKED_KEYS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_item           (q_item),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.accepted         (accepted),
		.armed            (armed),
		.throttle_command (throttle_command),
		.pitch_target     (pitch_target),
		.roll_target      (roll_target),
		.yaw_target       (yaw_target),
		.click_flags      (click_flags)
	);

endmodule
